// File: design/running_median_filter_unit_macros.svh
// Assertion macros used by the running median filter top level.
`ifndef RUNNING_MEDIAN_FILTER_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rmf_pkg.sv
// Types and constants shared by the running median filter modules.
`default_nettype none

package rmf_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_WIDTH = 16;
    localparam int IDX_W        = $clog2(MAX_WINDOW);
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int CFG_LEN_W    = 5;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RESET = CFG_LEN_W'(16);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        logic    vld;
        logic    gt;
        t_sample val;
    } t_cell;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SORT = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: design/rmf_if.sv
// Valid/ready channel interfaces for the input samples and the median results.
`default_nettype none

interface rmf_in_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;
    logic    restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rmf_out_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// File: design/running_median_filter_unit.sv
// Top level of the running median filter: window store, sequencer and result register.
//
// Samples arrive on the valid/ready input channel i_in, one per beat, with a restart
// flag that clears the fill count before the sample is stored. Each input beat gives
// exactly one median beat on the output channel o_out.
// The window length register sits at APB byte address 0 and must be written only
// while the block is idle, which the block itself does not enforce; 0 acts as 1 and
// values above 16 act as 16. After a sample is accepted, the L window samples, L being
// the effective window length, are fed one per cycle into a row of insertion-sort
// cells; the median is then picked and loaded into the output register once that
// register is free. A new sample is taken only after that median has been loaded.
// A finished median waits in the output register while the receiver stalls; the
// next item is sorted meanwhile and held until that register is free.
// Reset clears the window to zeros, the fill count to zero, the window length to 16
// and empties the output register.
`default_nettype none
`include "running_median_filter_unit_macros.svh"

module running_median_filter_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    rmf_in_if.sink                                  i_in,
    rmf_out_if.source                               o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [rmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [rmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);
    import rmf_pkg::*;

    logic [CFG_LEN_W-1:0] r_window_length;
    t_sample              r_window [MAX_WINDOW];
    t_sample              n_window [MAX_WINDOW];
    logic [CNT_W-1:0]     r_fill_count;
    logic [CNT_W-1:0]     n_fill_count;
    t_state               r_state;
    t_state               n_state;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_out_valid;
    t_sample              r_median;

    logic [CNT_W-1:0]     w_len;
    logic [CNT_W-1:0]     w_len_m1;
    logic [CNT_W-1:0]     w_half;
    logic [CNT_W-1:0]     w_fc_eff;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_load;
    logic                 w_last;
    t_sample              w_sorted [MAX_WINDOW];
    t_sample              w_hi;
    t_sample              w_lo;
    logic [SAMPLE_WIDTH:0] w_sum;
    t_sample              w_median;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH)
                  ? APB_DATA_W'(r_window_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_WINDOW_LENGTH) begin
            r_window_length <= pwdata[CFG_LEN_W-1:0];
        end
    end

    always_comb begin
        if (r_window_length == '0) begin
            w_len = CNT_W'(1);
        end else if (32'(r_window_length) > MAX_WINDOW) begin
            w_len = CNT_W'(MAX_WINDOW);
        end else begin
            w_len = CNT_W'(r_window_length);
        end
    end

    assign w_len_m1 = w_len - CNT_W'(1);
    assign w_half   = w_len >> 1;

    // Window store update.
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_fc_eff   = i_in.restart ? '0 : r_fill_count;

    always_comb begin
        n_window     = r_window;
        n_fill_count = r_fill_count;
        if (w_in_acc) begin
            if (w_fc_eff < w_len) begin
                n_window[w_fc_eff[IDX_W-1:0]] = i_in.sample;
                n_fill_count = w_fc_eff + CNT_W'(1);
            end else begin
                for (int i = 0; i < MAX_WINDOW; i++) begin
                    if (CNT_W'(i + 1) < w_len) begin
                        n_window[i] = r_window[i + 1 < MAX_WINDOW ? i + 1 : i];
                    end else if (CNT_W'(i) == w_len_m1) begin
                        n_window[i] = i_in.sample;
                    end
                end
                n_fill_count = w_fc_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                r_window[i] <= '0;
            end
            r_fill_count <= '0;
        end else begin
            r_window     <= n_window;
            r_fill_count <= n_fill_count;
        end
    end

    // Sequencer.
    assign w_last     = ({1'b0, r_idx} == w_len_m1);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_load     = (r_state == ST_DONE) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SORT) begin
                r_idx <= r_idx + IDX_W'(1);
            end else begin
                r_idx <= '0;
            end
        end
    end

    rmf_sort_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_in_acc),
        .i_insert (r_state == ST_SORT),
        .i_sample (r_window[r_idx]),
        .o_sorted (w_sorted)
    );

    // Median pick and floor average of the two middle values.
    assign w_hi     = w_sorted[w_half[IDX_W-1:0]];
    assign w_lo     = w_sorted[w_half[IDX_W-1:0] - IDX_W'(1)];
    assign w_sum    = {w_hi[SAMPLE_WIDTH-1], w_hi} + {w_lo[SAMPLE_WIDTH-1], w_lo};
    assign w_median = w_len[0] ? w_hi : t_sample'(w_sum[SAMPLE_WIDTH:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_median <= w_median;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.median = r_median;

    `RMF_ASSERT_NEXT(a_acc_starts_sort, i_clk, i_rst_n, w_in_acc, r_state == ST_SORT && r_idx == '0, "accepted beat did not start sorting")
    `RMF_ASSERT_NEXT(a_sort_ends, i_clk, i_rst_n, r_state == ST_SORT && w_last, r_state == ST_DONE, "sorting did not end after the last window sample")
    `RMF_ASSERT_IMPL(a_idx_in_window, i_clk, i_rst_n, r_state == ST_SORT, ({1'b0, r_idx} < w_len), "sort index ran past the window")
    `RMF_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load, r_out_valid && r_state == ST_IDLE, "median was not loaded into the output register")

endmodule

`default_nettype wire

// File: design/rmf_sort_cell.sv
// One insertion-sort cell: holds one sorted value and takes either its left neighbor's or the new sample.
`default_nettype none

module rmf_sort_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_clear,
    input  wire logic           i_insert,
    input  rmf_pkg::t_sample    i_sample,
    input  rmf_pkg::t_cell      i_left,
    output rmf_pkg::t_cell      o_cell
);
    import rmf_pkg::*;

    logic    r_vld;
    t_sample r_val;
    logic    w_gt;

    // The new sample belongs at or before this cell.
    assign w_gt = !r_vld || (r_val > i_sample);

    assign o_cell.vld = r_vld;
    assign o_cell.gt  = w_gt;
    assign o_cell.val = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_clear) begin
            r_vld <= 1'b0;
        end else if (i_insert && w_gt) begin
            r_vld <= i_left.gt ? i_left.vld : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert && w_gt) begin
            r_val <= i_left.gt ? i_left.val : i_sample;
        end
    end

endmodule

`default_nettype wire

// File: design/rmf_sort_chain.sv
// Row of insertion-sort cells that keeps the inserted samples in ascending order.
`default_nettype none

module rmf_sort_chain (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_clear,
    input  wire logic           i_insert,
    input  rmf_pkg::t_sample    i_sample,
    output rmf_pkg::t_sample    o_sorted [rmf_pkg::MAX_WINDOW]
);
    import rmf_pkg::*;

    t_cell w_cell [MAX_WINDOW];
    t_cell w_head;

    // The boundary left of the first cell never takes the sample's place.
    assign w_head.vld = 1'b1;
    assign w_head.gt  = 1'b0;
    assign w_head.val = '0;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        rmf_sort_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_clear  (i_clear),
            .i_insert (i_insert),
            .i_sample (i_sample),
            .i_left   ((g == 0) ? w_head : w_cell[(g == 0) ? 0 : g - 1]),
            .o_cell   (w_cell[g])
        );
        assign o_sorted[g] = w_cell[g].val;
    end

endmodule

`default_nettype wire

// File: bench/tb_running_median_filter_unit.sv
// Self-checking testbench for the running median filter: stimulus, prediction and scoring.
`timescale 1ns / 1ps

module tb_running_median_filter_unit;
    import rmf_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 3;
    localparam int IDLE_GAP     = 2 * MAX_WINDOW + 8;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 38;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_LENGTH =
        APB_ADDR_W'(4 * int'(REG_WINDOW_LENGTH));

    typedef enum int {
        RX_OPEN,
        RX_SPARSE,
        RX_PERIODIC,
        RX_COIN
    } t_rx_mode;

    class median_scoreboard;
        t_sample               window[MAX_WINDOW];
        int unsigned           fill_count;
        logic [CFG_LEN_W-1:0]  length_reg;
        t_sample               pending_medians[$];
        int unsigned           mismatches;

        function new();
            foreach (window[i]) window[i] = '0;
            fill_count = 0;
            length_reg = WINDOW_LENGTH_RESET;
            mismatches = 0;
        endfunction

        function void set_length(logic [CFG_LEN_W-1:0] value);
            length_reg = value;
        endfunction

        function int unsigned active_length();
            if (length_reg == '0) begin
                return 1;
            end
            if (int'(length_reg) > MAX_WINDOW) begin
                return MAX_WINDOW;
            end
            return int'(length_reg);
        endfunction

        function void take_sample(t_sample s, logic restart);
            int unsigned len;
            int unsigned half;
            int          j;
            int          pair_sum;
            t_sample     ordered[MAX_WINDOW];
            t_sample     v;
            t_sample     med;
            len  = active_length();
            half = len / 2;
            if (restart) begin
                fill_count = 0;
            end
            if (fill_count < len) begin
                window[fill_count] = s;
                fill_count++;
            end else begin
                for (int i = 0; i + 1 < len; i++) begin
                    window[i] = window[i + 1];
                end
                window[len - 1] = s;
            end
            for (int i = 0; i < len; i++) begin
                v = window[i];
                j = i;
                while (j > 0 && ordered[j - 1] > v) begin
                    ordered[j] = ordered[j - 1];
                    j--;
                end
                ordered[j] = v;
            end
            if (len % 2 == 1) begin
                med = ordered[half];
            end else begin
                pair_sum = int'(ordered[half - 1]) + int'(ordered[half]);
                med = t_sample'(pair_sum >>> 1);
            end
            pending_medians.push_back(med);
        endfunction

        function void check_median(t_sample got);
            t_sample want;
            if (pending_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected median beat: got %0d", got);
                end
                return;
            end
            want = pending_medians.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("median mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rmf_in_if  in_ch();
    rmf_out_if out_ch();

    median_scoreboard sb = new();
    int unsigned      burst_left = 0;
    bit               long_hold_req = 1'b0;

    running_median_filter_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.take_sample(in_ch.sample, in_ch.restart);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_median(out_ch.median);
            end
        end
    end

    initial begin
        t_rx_mode mode;
        int       span;
        out_ch.ready = 1'b0;
        forever begin
            if (long_hold_req) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(8, 60);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:     out_ch.ready <= 1'b1;
                    RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: out_ch.ready <= (k % 5 != 4);
                    default:     out_ch.ready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    task automatic send_sample(input t_sample s, input logic restart);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.restart <= restart;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_medians.size() != 0) @(negedge i_clk);
        repeat (IDLE_GAP) @(negedge i_clk);
    endtask

    task automatic write_window_length(input logic [CFG_LEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_LENGTH;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_length(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_sample random_sample();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return t_sample'($urandom());
            4, 5:       return t_sample'(int'($urandom_range(0, 8)) - 4);
            6: begin
                case ($urandom_range(0, 3))
                    0:       return t_sample'(16'sh7FFF);
                    1:       return t_sample'(16'sh8000);
                    2:       return t_sample'(-1);
                    default: return t_sample'(0);
                endcase
            end
            default:    return t_sample'(100);
        endcase
    endfunction

    initial begin
        logic [CFG_LEN_W-1:0] phase_lengths[12] = '{
            5'd1, 5'd2, 5'd3, 5'd16, 5'd0, 5'd31, 5'd7, 5'd8, 5'd17, 5'd4, 5'd15, 5'd5
        };
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.restart = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample(t_sample'(16'sh7FFF), 1'b0);
        send_sample(t_sample'(16'sh8000), 1'b0);
        send_sample(t_sample'(16'sh7FFF), 1'b0);
        send_sample(t_sample'(16'sh8000), 1'b0);
        send_sample(t_sample'(-1), 1'b0);
        send_sample(t_sample'(1), 1'b0);
        send_sample(t_sample'(0), 1'b0);
        send_sample(t_sample'(16'h5555), 1'b0);
        send_sample(t_sample'(16'hAAAA), 1'b0);

        // The fill count is past the new length, so the window shifts at once.
        wait_idle();
        write_window_length(5'd3);
        send_sample(t_sample'(100), 1'b0);
        send_sample(t_sample'(-100), 1'b0);
        send_sample(t_sample'(16'sh7FFF), 1'b0);
        send_sample(t_sample'(16'sh8000), 1'b1);
        send_sample(t_sample'(5), 1'b0);

        wait_idle();
        write_window_length(5'd0);
        send_sample(t_sample'(-7), 1'b0);
        send_sample(t_sample'(16'sh7FFF), 1'b1);

        wait_idle();
        write_window_length(5'd31);
        send_sample(t_sample'(12), 1'b0);
        send_sample(t_sample'(16'sh8000), 1'b0);

        wait_idle();
        write_window_length(5'd2);
        send_sample(t_sample'(16'sh7FFF), 1'b1);
        send_sample(t_sample'(16'sh8000), 1'b0);

        foreach (phase_lengths[p]) begin
            wait_idle();
            write_window_length(phase_lengths[p]);
            if (phase_lengths[p] == 5'd16) begin
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(random_sample(), $urandom_range(0, 11) == 0);
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.pending_medians.size() != 0) @(negedge i_clk);
        repeat (IDLE_GAP) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_medians.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/rmf_pkg.sv
design/rmf_if.sv
design/rmf_sort_cell.sv
design/rmf_sort_chain.sv
design/running_median_filter_unit.sv
bench/tb_running_median_filter_unit.sv
